@@ src/sha256bc_pkg.sv @@
package sha256bc_pkg;

  typedef logic [31:0] word_t;

  // eight working or chaining words, index 0 is a / h0
  typedef logic [0:7][31:0] hash_t;

  localparam int unsigned NumRounds = 64;
  localparam int unsigned RndW      = $clog2(NumRounds);

  // controls for the message schedule window
  typedef struct packed {
    logic push;
    logic step;
  } sched_ctrl_t;

  // controls for the round unit
  typedef struct packed {
    logic load;
    logic step;
  } round_ctrl_t;

  localparam hash_t InitHash = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [NumRounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t big_sigma0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  function automatic word_t choose(input word_t e, input word_t f, input word_t g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic word_t majority(input word_t a, input word_t b, input word_t c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

@@ src/sha256bc_in_if.sv @@
interface sha256bc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] message_word;
  logic        start_of_message;
  logic        end_of_message;

  modport source (output valid, output message_word, output start_of_message,
                  output end_of_message, input ready);
  modport sink (input valid, input message_word, input start_of_message,
                input end_of_message, output ready);
endinterface

@@ src/sha256bc_out_if.sv @@
interface sha256bc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  digest_index;
  logic        digest_last;

  modport source (output valid, output digest_word, output digest_index,
                  output digest_last, input ready);
  modport sink (input valid, input digest_word, input digest_index,
                input digest_last, output ready);
endinterface

@@ src/sha256bc_sched.sv @@
module sha256bc_sched
  import sha256bc_pkg::*;
(
  input  logic        clk_i,
  input  sched_ctrl_t ctrl_i,
  input  word_t       word_i,
  output word_t       w_cur_o
);

  // sixteen-word window: entry 0 is the word for the current round
  word_t win_q [16];
  word_t w_next;

  // next schedule word from the window taps
  assign w_next = win_q[0] + small_sigma0(win_q[1]) + win_q[9] + small_sigma1(win_q[14]);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push || ctrl_i.step) begin
      for (int i = 0; i < 15; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[15] <= ctrl_i.push ? word_i : w_next;
    end
  end

  assign w_cur_o = win_q[0];

endmodule

@@ src/sha256bc_round.sv @@
module sha256bc_round
  import sha256bc_pkg::*;
(
  input  logic        clk_i,
  input  round_ctrl_t ctrl_i,
  input  hash_t       init_i,
  input  word_t       k_i,
  input  word_t       w_i,
  output hash_t       v_o
);

  hash_t v_q;
  word_t t1;
  word_t t2;

  // one compression round
  assign t1 = v_q[7] + big_sigma1(v_q[4]) + choose(v_q[4], v_q[5], v_q[6]) + k_i + w_i;
  assign t2 = big_sigma0(v_q[0]) + majority(v_q[0], v_q[1], v_q[2]);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      v_q <= init_i;
    end else if (ctrl_i.step) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  assign v_o = v_q;

endmodule

@@ src/sha256_block_compress_core.sv @@
// SHA-256 compression core fed with an already padded message, one 32-bit
// big-endian word per input transfer. A word that does not complete a block
// is taken without holding the input off. The sixteenth word of a block holds
// the input off for 64 rounds through the single round unit, one per cycle,
// then for a final step that adds the working words into the chaining value.
// A word with end_of_message set is followed by eight digest transfers,
// index 0 first; the first one is presented once the core has entered its
// emit state and registered the word, and the rest follow one per cycle
// while the sink is ready. No input is taken until the last digest word has
// been transferred.
module sha256_block_compress_core
  import sha256bc_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  sha256bc_in_if.sink    in_i,
  sha256bc_out_if.source out_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINAL,
    ST_EMIT
  } state_e;

  state_e          state_q, state_d;
  logic [3:0]      cnt_q, cnt_d;
  logic [RndW-1:0] rnd_q, rnd_d;
  logic            end_q, end_d;
  hash_t           chain_q, chain_d;
  logic [2:0]      idx_q, idx_d;
  logic            out_valid_q, out_valid_d;
  word_t           out_word_q, out_word_d;

  logic            in_xfer;
  logic [3:0]      cnt_base;
  sched_ctrl_t     sched_ctrl;
  round_ctrl_t     round_ctrl;
  word_t           w_cur;
  hash_t           v_cur;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;

  sha256bc_sched u_sched (
    .clk_i   (clk_i),
    .ctrl_i  (sched_ctrl),
    .word_i  (in_i.message_word),
    .w_cur_o (w_cur)
  );

  sha256bc_round u_round (
    .clk_i  (clk_i),
    .ctrl_i (round_ctrl),
    .init_i (chain_q),
    .k_i    (RoundK[rnd_q]),
    .w_i    (w_cur),
    .v_o    (v_cur)
  );

  // sequencer next state
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rnd_d       = rnd_q;
    end_d       = end_q;
    chain_d     = chain_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    sched_ctrl  = '0;
    round_ctrl  = '0;
    cnt_base    = in_i.start_of_message ? 4'd0 : cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          sched_ctrl.push = 1'b1;
          cnt_d = cnt_base + 4'd1;
          end_d = in_i.end_of_message;
          if (in_i.start_of_message) begin
            chain_d = InitHash;
          end
          if (&cnt_base) begin
            // block complete: load working words and start the rounds
            round_ctrl.load = 1'b1;
            rnd_d   = '0;
            state_d = ST_ROUND;
          end else if (in_i.end_of_message) begin
            // partial block is dropped
            cnt_d   = '0;
            idx_d   = '0;
            state_d = ST_EMIT;
          end
        end
      end
      ST_ROUND: begin
        sched_ctrl.step = 1'b1;
        round_ctrl.step = 1'b1;
        rnd_d = rnd_q + 1'b1;
        if (&rnd_q) begin
          state_d = ST_FINAL;
        end
      end
      ST_FINAL: begin
        for (int i = 0; i < 8; i++) begin
          chain_d[i] = chain_q[i] + v_cur[i];
        end
        if (end_q) begin
          cnt_d   = '0;
          idx_d   = '0;
          state_d = ST_EMIT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q) begin
          out_valid_d = 1'b1;
          out_word_d  = chain_q[idx_q];
        end else if (out_o.ready) begin
          if (&idx_q) begin
            out_valid_d = 1'b0;
            state_d     = ST_IDLE;
          end else begin
            idx_d      = idx_q + 1'b1;
            out_word_d = chain_q[idx_q + 1'b1];
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      rnd_q       <= '0;
      end_q       <= 1'b0;
      chain_q     <= InitHash;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rnd_q       <= rnd_d;
      end_q       <= end_d;
      chain_q     <= chain_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      out_word_q  <= out_word_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.digest_word  = out_word_q;
  assign out_o.digest_index = idx_q;
  assign out_o.digest_last  = &idx_q;

  // no input is taken while a digest word is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !in_i.ready)
    else $error("input ready while digest pending");

  // a block-completing word stalls the input for the rounds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && !in_i.start_of_message && cnt_q == 4'd15) |=> !in_i.ready)
    else $error("input ready right after block completion");

  // the last digest transfer ends the digest burst
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.digest_last) |=> (!out_o.valid && in_i.ready))
    else $error("digest burst did not end after last word");

  // digest words come out in index order
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && !out_o.digest_last)
      |=> (out_o.valid && out_o.digest_index == $past(out_o.digest_index) + 3'd1))
    else $error("digest index out of order");

endmodule
